[rtl/vrr_pkg.sv]
package vrr_pkg;

  localparam int FRAC_BITS = 14;
  localparam int VEC_W     = 18;
  localparam int ETA_W     = 16;
  localparam int PROD_W    = 2 * VEC_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int DOT_W     = SUM_W - FRAC_BITS;
  localparam int D2_W      = 2 * DOT_W - FRAC_BITS;
  localparam int E2_W      = 2 * ETA_W - FRAC_BITS + 1;
  localparam int OMD_W     = D2_W + 1;
  localparam int P_W       = E2_W + OMD_W;
  localparam int K_W       = P_W - FRAC_BITS + 1;
  localparam int ROOT_W    = 24;
  localparam int RAD_W     = 2 * ROOT_W;
  localparam int REM_W     = ROOT_W + 1;
  localparam int RFL_W     = DOT_W + VEC_W - FRAC_BITS + 2;
  localparam int ED_W      = DOT_W + ETA_W + 1 - FRAC_BITS;
  localparam int EI_W      = VEC_W + ETA_W + 1 - FRAC_BITS;
  localparam int C_W       = ED_W + 1;
  localparam int CN_W      = C_W + VEC_W;
  localparam int RES_W     = CN_W - FRAC_BITS + 2;
  localparam int FRONT_STAGES = 5;
  localparam int OUT_MAX   = 131071;
  localparam int OUT_MIN   = -131072;
  localparam int ONE       = 1 << FRAC_BITS;

  typedef enum logic [1:0] {
    OP_REFLECT = 2'd0,
    OP_REFRACT = 2'd1,
    OP_FACEFWD = 2'd2
  } op_t;

  typedef logic signed [VEC_W-1:0]  vec_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [RFL_W-1:0]  rfl_t;
  typedef logic signed [EI_W-1:0]   ei_t;
  typedef logic signed [CN_W-1:0]   cn_t;

  typedef struct packed {
    op_t                      op;
    vec_t [2:0]               inc;
    vec_t [2:0]               nrm;
    logic [ETA_W-1:0]         eta;
    prod_t [2:0]              prod;
    logic signed [DOT_W-1:0]  dot;
    logic                     neg;
    rfl_t [2:0]               refl;
    logic signed [ED_W-1:0]   ed;
    ei_t [2:0]                ei;
    logic signed [E2_W-1:0]   e2;
    logic signed [D2_W-1:0]   d2;
    logic signed [P_W-1:0]    p;
    logic                     tir;
    logic [RAD_W-1:0]         rad;
    logic [REM_W-1:0]         rem;
    logic [ROOT_W-1:0]        root;
    cn_t [2:0]                cn;
  } item_t;

endpackage

[rtl/vrr_front.sv]
module vrr_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  vrr_pkg::item_t in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output vrr_pkg::item_t out_item
);

  localparam int NS = vrr_pkg::FRONT_STAGES;

  vrr_pkg::item_t st  [NS];
  vrr_pkg::item_t nxt [NS];
  logic [NS-1:0]  v;
  logic [NS:0]    adv;

  logic signed [vrr_pkg::SUM_W-1:0]              sum;
  logic signed [2*vrr_pkg::DOT_W-1:0]            sq;
  logic [2*vrr_pkg::ETA_W-1:0]                   ee;
  logic signed [vrr_pkg::ETA_W:0]                etas;
  logic signed [vrr_pkg::DOT_W+vrr_pkg::ETA_W:0] edp;
  logic signed [vrr_pkg::VEC_W+vrr_pkg::ETA_W:0] eip [3];
  logic signed [vrr_pkg::DOT_W+vrr_pkg::VEC_W-1:0] dn [3];
  logic signed [vrr_pkg::RFL_W-2:0]              tr [3];
  logic signed [vrr_pkg::OMD_W-1:0]              omd;
  logic signed [vrr_pkg::P_W-vrr_pkg::FRAC_BITS-1:0] pk;
  logic signed [vrr_pkg::K_W-1:0]                k;

  always_comb begin
    adv[NS] = out_ready;
    for (int i = NS - 1; i >= 0; i--) begin
      adv[i] = !v[i] || adv[i+1];
    end
  end

  always_comb begin
    nxt[0] = in_item;
    for (int i = 0; i < 3; i++) begin
      nxt[0].prod[i] = in_item.inc[i] * in_item.nrm[i];
    end

    nxt[1] = st[0];
    sum = vrr_pkg::SUM_W'(st[0].prod[0]) + vrr_pkg::SUM_W'(st[0].prod[1])
        + vrr_pkg::SUM_W'(st[0].prod[2]);
    nxt[1].dot = sum[vrr_pkg::SUM_W-1:vrr_pkg::FRAC_BITS];
    nxt[1].neg = sum[vrr_pkg::SUM_W-1];

    nxt[2] = st[1];
    sq   = st[1].dot * st[1].dot;
    ee   = st[1].eta * st[1].eta;
    etas = signed'({1'b0, st[1].eta});
    edp  = etas * st[1].dot;
    nxt[2].d2 = sq[2*vrr_pkg::DOT_W-1:vrr_pkg::FRAC_BITS];
    nxt[2].e2 = signed'(vrr_pkg::E2_W'(ee >> vrr_pkg::FRAC_BITS));
    nxt[2].ed = edp[vrr_pkg::DOT_W+vrr_pkg::ETA_W:vrr_pkg::FRAC_BITS];
    for (int i = 0; i < 3; i++) begin
      eip[i] = etas * st[1].inc[i];
      dn[i]  = st[1].dot * st[1].nrm[i];
      tr[i]  = dn[i][vrr_pkg::DOT_W+vrr_pkg::VEC_W-1:vrr_pkg::FRAC_BITS-1];
      nxt[2].ei[i]   = eip[i][vrr_pkg::VEC_W+vrr_pkg::ETA_W:vrr_pkg::FRAC_BITS];
      nxt[2].refl[i] = vrr_pkg::RFL_W'(st[1].inc[i]) - vrr_pkg::RFL_W'(tr[i]);
    end

    nxt[3] = st[2];
    omd = vrr_pkg::OMD_W'(vrr_pkg::ONE) - vrr_pkg::OMD_W'(st[2].d2);
    nxt[3].p = st[2].e2 * omd;

    nxt[4] = st[3];
    pk = st[3].p[vrr_pkg::P_W-1:vrr_pkg::FRAC_BITS];
    k  = vrr_pkg::K_W'(vrr_pkg::ONE) - vrr_pkg::K_W'(pk);
    nxt[4].tir  = (st[3].op == vrr_pkg::OP_REFRACT) && k[vrr_pkg::K_W-1];
    nxt[4].rad  = k[vrr_pkg::K_W-1] ? '0 :
                  {k[vrr_pkg::RAD_W-vrr_pkg::FRAC_BITS-1:0], {vrr_pkg::FRAC_BITS{1'b0}}};
    nxt[4].rem  = '0;
    nxt[4].root = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) v[0] <= in_valid;
      for (int i = 1; i < NS; i++) begin
        if (adv[i]) v[i] <= v[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NS; i++) begin
      if (adv[i]) st[i] <= nxt[i];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = v[NS-1];
  assign out_item  = st[NS-1];

endmodule

[rtl/vrr_sqrt_cell.sv]
module vrr_sqrt_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  vrr_pkg::item_t in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output vrr_pkg::item_t out_item
);

  vrr_pkg::item_t             item;
  vrr_pkg::item_t             item_next;
  logic                       valid;
  logic [vrr_pkg::ROOT_W+2:0] rem2;
  logic [vrr_pkg::ROOT_W+2:0] trial;
  logic [vrr_pkg::ROOT_W+2:0] diff;

  assign in_ready = !valid || out_ready;

  always_comb begin
    item_next = in_item;
    rem2  = {in_item.rem, in_item.rad[vrr_pkg::RAD_W-1 -: 2]};
    trial = {1'b0, in_item.root, 2'b01};
    diff  = rem2 - trial;
    item_next.rad = {in_item.rad[vrr_pkg::RAD_W-3:0], 2'b00};
    if (rem2 >= trial) begin
      item_next.rem  = diff[vrr_pkg::REM_W-1:0];
      item_next.root = {in_item.root[vrr_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      item_next.rem  = rem2[vrr_pkg::REM_W-1:0];
      item_next.root = {in_item.root[vrr_pkg::ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) item <= item_next;
  end

  assign out_valid = valid;
  assign out_item  = item;

endmodule

[rtl/vrr_back.sv]
module vrr_back (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  vrr_pkg::item_t           in_item,
  output logic                     out_valid,
  input  logic                     out_ready,
  output vrr_pkg::vec_t [2:0]      res,
  output logic                     tir
);

  vrr_pkg::item_t                  sf;
  vrr_pkg::item_t                  sf_next;
  logic                            vf;
  logic                            adv_f;
  logic                            adv_o;
  logic                            ov;
  logic signed [vrr_pkg::C_W-1:0]  c;
  logic signed [vrr_pkg::CN_W-vrr_pkg::FRAC_BITS-1:0] cs [3];
  logic signed [vrr_pkg::RES_W-1:0] r [3];
  vrr_pkg::vec_t [2:0]             res_next;

  assign adv_o    = !ov || out_ready;
  assign adv_f    = !vf || adv_o;
  assign in_ready = adv_f;

  always_comb begin
    sf_next = in_item;
    c = vrr_pkg::C_W'(in_item.ed) + vrr_pkg::C_W'(signed'({1'b0, in_item.root}));
    for (int i = 0; i < 3; i++) begin
      sf_next.cn[i] = c * in_item.nrm[i];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cs[i] = sf.cn[i][vrr_pkg::CN_W-1:vrr_pkg::FRAC_BITS];
      case (sf.op)
        vrr_pkg::OP_REFLECT: r[i] = vrr_pkg::RES_W'(sf.refl[i]);
        vrr_pkg::OP_REFRACT: r[i] = sf.tir ? '0 :
                               vrr_pkg::RES_W'(sf.ei[i]) - vrr_pkg::RES_W'(cs[i]);
        vrr_pkg::OP_FACEFWD: r[i] = sf.neg ? vrr_pkg::RES_W'(sf.nrm[i]) :
                                             -vrr_pkg::RES_W'(sf.nrm[i]);
        default:             r[i] = '0;
      endcase
      if (r[i] > vrr_pkg::RES_W'(vrr_pkg::OUT_MAX)) begin
        res_next[i] = vrr_pkg::vec_t'(vrr_pkg::OUT_MAX);
      end else if (r[i] < vrr_pkg::RES_W'(vrr_pkg::OUT_MIN)) begin
        res_next[i] = vrr_pkg::vec_t'(vrr_pkg::OUT_MIN);
      end else begin
        res_next[i] = r[i][vrr_pkg::VEC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vf <= 1'b0;
      ov <= 1'b0;
    end else begin
      if (adv_f) vf <= in_valid;
      if (adv_o) ov <= vf;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_f) sf <= sf_next;
    if (adv_o) begin
      res <= res_next;
      tir <= sf.tir;
    end
  end

  assign out_valid = ov;

endmodule

[rtl/vector_reflect_refract_unit_core.sv]
// Shading vector unit: reflect, refract and faceforward on fixed-point
// vectors with 14 fraction bits.
// Input channel s_*: one transfer carries an operation (tuser) and the
// incident vector, normal and index ratio (tdata). Output channel m_*:
// one transfer per input carries the saturated result vector (tdata)
// and the total internal reflection flag (tuser).
// From input transfer to m_tvalid an item passes five front stages
// (products, dot product, squares, refraction product, radicand), a chain
// of 24 square-root cells producing one root bit each, a normal-scaling
// stage and the output register.
// Throughput is one item per cycle while m_tready is high; every stage is a
// register with its own valid bit, so bubbles close up and s_tready stays
// high while any stage has room, even with a result waiting at the output.
// When m_tready is low, the output holds and stages fill behind it;
// s_tready drops only once every stage holds an item.
// Reset clears all valid bits; the data registers are not reset.
module vector_reflect_refract_unit_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,  // inc_x, inc_y, inc_z, nrm_x, nrm_y, nrm_z, index_ratio
  input  logic [1:0]   s_tuser,  // operation
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [55:0]  m_tdata,  // res_x, res_y, res_z
  output logic [0:0]   m_tuser   // total_internal
);

  localparam int NC = vrr_pkg::ROOT_W;

  vrr_pkg::item_t      in_item;
  vrr_pkg::item_t      cell_item  [NC+1];
  logic [NC:0]         cell_valid;
  logic [NC:0]         cell_ready;
  logic                back_ready;
  vrr_pkg::vec_t [2:0] res;
  logic                tir;

  always_comb begin
    in_item        = '0;
    in_item.op     = vrr_pkg::op_t'(s_tuser);
    in_item.inc[0] = s_tdata[17:0];
    in_item.inc[1] = s_tdata[35:18];
    in_item.inc[2] = s_tdata[53:36];
    in_item.nrm[0] = s_tdata[71:54];
    in_item.nrm[1] = s_tdata[89:72];
    in_item.nrm[2] = s_tdata[107:90];
    in_item.eta    = s_tdata[123:108];
  end

  vrr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (in_item),
    .out_valid (cell_valid[0]),
    .out_ready (cell_ready[0]),
    .out_item  (cell_item[0])
  );

  for (genvar g = 0; g < NC; g++) begin : g_cell
    vrr_sqrt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cell_valid[g]),
      .in_ready  (cell_ready[g]),
      .in_item   (cell_item[g]),
      .out_valid (cell_valid[g+1]),
      .out_ready (cell_ready[g+1]),
      .out_item  (cell_item[g+1])
    );
  end

  assign cell_ready[NC] = back_ready;

  vrr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cell_valid[NC]),
    .in_ready  (back_ready),
    .in_item   (cell_item[NC]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .res       (res),
    .tir       (tir)
  );

  assign m_tdata = {2'b00, res[2], res[1], res[0]};
  assign m_tuser = tir;

  a_tir_zero : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[53:0] == '0)
    else $error("total internal reflection with nonzero vector");

  a_ready_when_empty : assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  a_reset_clears : assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");

endmodule
